/* hw/rtl/rhcc_pkg.sv */
// Shared types and constants for the RGB/HSV color converter.
`timescale 1ns / 1ps
`default_nettype none

package rhcc_pkg;

    localparam int PIPE_DEPTH = 7;

    localparam logic REQ_TO_HSV = 1'b0;
    localparam logic REQ_TO_RGB = 1'b1;

    localparam logic [7:0] HUE_STEP  = 8'd43;
    localparam logic [7:0] HUE_GREEN = 8'd85;
    localparam logic [7:0] HUE_BLUE  = 8'd171;
    localparam logic [7:0] FULL      = 8'd255;
    localparam logic [7:0] REM_SCALE = 8'd6;

    localparam logic [7:0] HUE_B1 = 8'(1 * 43);
    localparam logic [7:0] HUE_B2 = 8'(2 * 43);
    localparam logic [7:0] HUE_B3 = 8'(3 * 43);
    localparam logic [7:0] HUE_B4 = 8'(4 * 43);
    localparam logic [7:0] HUE_B5 = 8'(5 * 43);

    localparam logic [1:0] SEL_R = 2'd0;
    localparam logic [1:0] SEL_G = 2'd1;
    localparam logic [1:0] SEL_B = 2'd2;

    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;

    typedef struct packed {
        logic       req_type;
        logic [7:0] chan_a;
        logic [7:0] chan_b;
        logic [7:0] chan_c;
    } t_req;

    typedef struct packed {
        logic [7:0] out_a;
        logic [7:0] out_b;
        logic [7:0] out_c;
    } t_res;

endpackage

`default_nettype wire

/* hw/rtl/rgb_hsv_color_converter.sv */
// Pipelined RGB to HSV and HSV to RGB pixel converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts one pixel of three 8-bit channels per clock, while i_stall is low,
// in either direction, selected per request by req_type. The pipeline has seven
// register stages, and throughput is one request per cycle while no
// backpressure holds it. The depth is set by the
// two restoring dividers (saturation and hue offset), which resolve two
// quotient bits per stage over four stages after the max/min and product
// stages. Backpressure on i_stall holds the output stage; empty stages still
// advance, so bubbles close up and o_stall rises only when every stage is full.
module rgb_hsv_color_converter (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  rhcc_pkg::t_req       i_req,
    output logic                 o_valid,
    input  wire                  i_stall,
    output rhcc_pkg::t_res       o_res
);
    import rhcc_pkg::*;

    typedef struct packed {
        logic        dir;
        logic [7:0]  mx;
        logic [7:0]  dels;
        logic [1:0]  sel;
        logic        neg;
        logic [7:0]  mag;
        logic [15:0] divs;
        logic [15:0] divh;
        logic [7:0]  s;
        logic [7:0]  v;
        logic [2:0]  region;
        logic [7:0]  rem;
        logic [7:0]  ps;
        logic [7:0]  pt;
        logic [7:0]  p;
        logic [7:0]  q;
        logic [7:0]  t;
    } t_stage;

    function automatic logic [15:0] div_step(input logic [15:0] x, input logic [7:0] dv);
        logic [8:0] tr;
        logic [8:0] df;
        logic [15:0] res;
        tr = {x[15:8], x[7]};
        df = tr - {1'b0, dv};
        if (tr >= {1'b0, dv}) begin
            res = {df[7:0], x[6:0], 1'b1};
        end else begin
            res = {tr[7:0], x[6:0], 1'b0};
        end
        return res;
    endfunction

    function automatic logic [7:0] mul_hi(input logic [7:0] x, input logic [7:0] y);
        logic [15:0] pr;
        pr = {8'd0, x} * {8'd0, y};
        return pr[15:8];
    endfunction

    logic [PIPE_DEPTH-1:0] r_v;
    logic [PIPE_DEPTH-1:0] adv;
    t_stage                r_st [PIPE_DEPTH-1];
    t_stage                n_st [PIPE_DEPTH-1];
    t_res                  r_out;
    t_res                  n_out;

    logic [7:0] mx0;
    logic [7:0] mn0;
    logic [7:0] base43;
    logic [7:0] rd0;
    logic [7:0] hbase;
    logic [7:0] qs;
    logic [7:0] qh;

    // stall chain: a stage moves when it is empty or the next one moves
    always_comb begin
        adv[PIPE_DEPTH-1] = !r_v[PIPE_DEPTH-1] || !i_stall;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_v[PIPE_DEPTH-1];
    assign o_res   = r_out;

    // stage 0: max/min, hue difference, sector and remainder
    always_comb begin
        n_st[0] = '0;
        n_st[0].dir = i_req.req_type;
        mx0 = i_req.chan_a;
        mn0 = i_req.chan_a;
        if (i_req.chan_b > mx0) mx0 = i_req.chan_b;
        if (i_req.chan_c > mx0) mx0 = i_req.chan_c;
        if (i_req.chan_b < mn0) mn0 = i_req.chan_b;
        if (i_req.chan_c < mn0) mn0 = i_req.chan_c;
        n_st[0].mx   = mx0;
        n_st[0].dels = mx0 - mn0;
        if (mx0 == i_req.chan_a) begin
            n_st[0].sel = SEL_R;
            n_st[0].neg = i_req.chan_c > i_req.chan_b;
            n_st[0].mag = (i_req.chan_c > i_req.chan_b) ? i_req.chan_c - i_req.chan_b
                                                        : i_req.chan_b - i_req.chan_c;
        end else if (mx0 == i_req.chan_b) begin
            n_st[0].sel = SEL_G;
            n_st[0].neg = i_req.chan_a > i_req.chan_c;
            n_st[0].mag = (i_req.chan_a > i_req.chan_c) ? i_req.chan_a - i_req.chan_c
                                                        : i_req.chan_c - i_req.chan_a;
        end else begin
            n_st[0].sel = SEL_B;
            n_st[0].neg = i_req.chan_b > i_req.chan_a;
            n_st[0].mag = (i_req.chan_b > i_req.chan_a) ? i_req.chan_b - i_req.chan_a
                                                        : i_req.chan_a - i_req.chan_b;
        end

        n_st[0].s = i_req.chan_b;
        n_st[0].v = i_req.chan_c;
        if (i_req.chan_a < HUE_B1) begin
            n_st[0].region = SECTOR_0;
            base43 = 8'd0;
        end else if (i_req.chan_a < HUE_B2) begin
            n_st[0].region = SECTOR_1;
            base43 = HUE_B1;
        end else if (i_req.chan_a < HUE_B3) begin
            n_st[0].region = SECTOR_2;
            base43 = HUE_B2;
        end else if (i_req.chan_a < HUE_B4) begin
            n_st[0].region = SECTOR_3;
            base43 = HUE_B3;
        end else if (i_req.chan_a < HUE_B5) begin
            n_st[0].region = SECTOR_4;
            base43 = HUE_B4;
        end else begin
            n_st[0].region = SECTOR_5;
            base43 = HUE_B5;
        end
        rd0 = i_req.chan_a - base43;
        n_st[0].rem = 8'({8'd0, rd0} * {8'd0, REM_SCALE});
    end

    // stage 1: dividends and first products
    always_comb begin
        n_st[1] = r_st[0];
        n_st[1].divs = {8'd0, r_st[0].dels} * {8'd0, FULL};
        n_st[1].divh = {8'd0, r_st[0].mag} * {8'd0, HUE_STEP};
        n_st[1].ps   = mul_hi(r_st[0].s, r_st[0].rem);
        n_st[1].pt   = mul_hi(r_st[0].s, FULL - r_st[0].rem);
        n_st[1].p    = mul_hi(r_st[0].v, FULL - r_st[0].s);
    end

    // stage 2: first two quotient bits, q and t levels
    always_comb begin
        n_st[2] = r_st[1];
        n_st[2].divs = div_step(div_step(r_st[1].divs, r_st[1].mx), r_st[1].mx);
        n_st[2].divh = div_step(div_step(r_st[1].divh, r_st[1].dels), r_st[1].dels);
        n_st[2].q    = mul_hi(r_st[1].v, FULL - r_st[1].ps);
        n_st[2].t    = mul_hi(r_st[1].v, FULL - r_st[1].pt);
    end

    // stages 3 to last-1: remaining quotient bits
    for (genvar k = 3; k < PIPE_DEPTH - 1; k++) begin : g_div
        always_comb begin
            n_st[k] = r_st[k-1];
            n_st[k].divs = div_step(div_step(r_st[k-1].divs, r_st[k-1].mx), r_st[k-1].mx);
            n_st[k].divh = div_step(div_step(r_st[k-1].divh, r_st[k-1].dels),
                                    r_st[k-1].dels);
        end
    end

    // output stage: hue, saturation and value assembly, or gray output and sector placement
    always_comb begin
        qs = r_st[PIPE_DEPTH-2].divs[7:0];
        qh = r_st[PIPE_DEPTH-2].divh[7:0];
        case (r_st[PIPE_DEPTH-2].sel)
            SEL_R:   hbase = 8'd0;
            SEL_G:   hbase = HUE_GREEN;
            default: hbase = HUE_BLUE;
        endcase
        n_out = '0;
        if (r_st[PIPE_DEPTH-2].dir == REQ_TO_HSV) begin
            n_out.out_c = r_st[PIPE_DEPTH-2].mx;
            if (r_st[PIPE_DEPTH-2].mx != 8'd0) begin
                n_out.out_b = qs;
                if (qs != 8'd0) begin
                    n_out.out_a = r_st[PIPE_DEPTH-2].neg ? hbase - qh : hbase + qh;
                end
            end
        end else if (r_st[PIPE_DEPTH-2].s == 8'd0) begin
            n_out.out_a = r_st[PIPE_DEPTH-2].v;
            n_out.out_b = r_st[PIPE_DEPTH-2].v;
            n_out.out_c = r_st[PIPE_DEPTH-2].v;
        end else begin
            case (r_st[PIPE_DEPTH-2].region)
                SECTOR_0: n_out = {r_st[PIPE_DEPTH-2].v, r_st[PIPE_DEPTH-2].t,
                                   r_st[PIPE_DEPTH-2].p};
                SECTOR_1: n_out = {r_st[PIPE_DEPTH-2].q, r_st[PIPE_DEPTH-2].v,
                                   r_st[PIPE_DEPTH-2].p};
                SECTOR_2: n_out = {r_st[PIPE_DEPTH-2].p, r_st[PIPE_DEPTH-2].v,
                                   r_st[PIPE_DEPTH-2].t};
                SECTOR_3: n_out = {r_st[PIPE_DEPTH-2].p, r_st[PIPE_DEPTH-2].q,
                                   r_st[PIPE_DEPTH-2].v};
                SECTOR_4: n_out = {r_st[PIPE_DEPTH-2].t, r_st[PIPE_DEPTH-2].p,
                                   r_st[PIPE_DEPTH-2].v};
                default:  n_out = {r_st[PIPE_DEPTH-2].v, r_st[PIPE_DEPTH-2].p,
                                   r_st[PIPE_DEPTH-2].q};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PIPE_DEPTH - 1; k++) begin
            if (adv[k]) r_st[k] <= n_st[k];
        end
        if (adv[PIPE_DEPTH-1]) r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_v) && i_stall)
        else $error("input stalled while the pipeline has room");

    a_valid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && adv[1]) |=> r_v[1])
        else $error("request lost between first stages");

    a_sat_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && r_st[3].dir == REQ_TO_HSV && r_st[3].mx != 8'd0)
            |-> r_st[3].divs[15:8] < r_st[3].mx)
        else $error("saturation divider remainder out of range");

    a_hue_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && r_st[3].dir == REQ_TO_HSV && r_st[3].dels != 8'd0)
            |-> r_st[3].divh[15:8] < r_st[3].dels)
        else $error("hue divider remainder out of range");
`endif

endmodule

`default_nettype wire
